>>> src/echo_chorus_delay_effect_defines.svh
// Assertion macros shared by the echo/chorus delay effect RTL.
// Depends on nothing; the using module must have clk_i and rst_ni.
`ifndef ECHO_CHORUS_DELAY_EFFECT_DEFINES_SVH
`define ECHO_CHORUS_DELAY_EFFECT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ECDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ECDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ecde_pkg.sv
// Package for the echo/chorus delay effect: sizes, register indexes,
// mode codes, shared structs and the chorus LFO factor table.
`default_nettype none

package ecde_pkg;

  // Store geometry
  localparam int unsigned DELAY_DEPTH  = 32768;
  localparam int unsigned ADDR_W       = $clog2(DELAY_DEPTH);
  localparam int unsigned CNT_W        = $clog2(DELAY_DEPTH + 1);

  // LFO sine table
  localparam int unsigned SINE_ENTRIES = 256;
  localparam int unsigned SIN_W        = $clog2(SINE_ENTRIES);

  // Command queue between front and back
  localparam int unsigned CMDQ_DEPTH   = 2;
  localparam int unsigned CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

  // Result queue
  localparam int unsigned RESQ_DEPTH   = 2;
  localparam int unsigned RESQ_PTR_W   = $clog2(RESQ_DEPTH);
  localparam int unsigned RESQ_CNT_W   = $clog2(RESQ_DEPTH + 1);

  // Register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_LENGTH   = 3'd1;
  localparam logic [2:0] REG_FEEDBACK = 3'd2;
  localparam logic [2:0] REG_OUT_GAIN = 3'd3;
  localparam logic [2:0] REG_LFO_STEP = 3'd4;

  // Effect modes (code 3 acts as off)
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_ECHO   = 2'd1;
  localparam logic [1:0] MODE_CHORUS = 2'd2;

  typedef struct packed {
    logic [1:0]  effect_mode;
    logic [15:0] delay_length;
    logic [15:0] feedback_gain;
    logic [15:0] output_gain;
    logic [15:0] lfo_step;
  } cfg_t;

  // One classified sample on its way to the back end
  typedef struct packed {
    logic signed [15:0] sample;
    logic [ADDR_W-1:0]  pos;
    logic               fresh;     // entry never visited since reset, reads zero
    logic [15:0]        chorus_f;  // Q1.15 chorus factor for this sample
  } cmd_t;

  typedef logic [15:0] chorus_lut_t [SINE_ENTRIES];

  // sin(pi/2 * r/16384) in Q15, odd 7th-order polynomial, r in 0..16384
  function automatic logic [15:0] quarter_sine(input logic [14:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = 64'(r) << 1;
    x2 = (x * x) >> 15;
    t  = 64'd2611 - ((64'd153 * x2) >> 15);
    t  = 64'd21167 - ((t * x2) >> 15);
    t  = 64'd51472 - ((t * x2) >> 15);
    t  = (t * x) >> 15;
    if (t > 64'd32767) t = 64'd32767;
    return t[15:0];
  endfunction

  // 32768 + sine/2 (half truncated toward zero) for one table step
  function automatic logic [15:0] chorus_factor(input int unsigned idx);
    logic [15:0] p;
    logic [14:0] rr;
    logic [15:0] s;
    logic [15:0] half;
    p    = 16'(idx << (16 - SIN_W));
    rr   = p[14] ? 15'(15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
    s    = quarter_sine(rr);
    half = s >> 1;
    return p[15] ? 16'(16'd32768 - half) : 16'(16'd32768 + half);
  endfunction

  function automatic chorus_lut_t build_chorus_lut();
    chorus_lut_t lut;
    for (int unsigned i = 0; i < SINE_ENTRIES; i++) begin
      lut[i] = chorus_factor(i);
    end
    return lut;
  endfunction

endpackage

`default_nettype wire

>>> src/ecde_front.sv
// Front end: tracks write position, fill mark and LFO phase, and turns each
// accepted sample into a command. Depends on ecde_pkg.
`default_nettype none

module ecde_front
  import ecde_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  cfg_t               cfg_i,
  input  wire                accept_i,
  input  wire signed [15:0]  in_sample_i,
  output cmd_t               cmd_o
);

  localparam chorus_lut_t ChorusLut = build_chorus_lut();

  logic [ADDR_W-1:0] write_pos_q, write_pos_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [15:0]       lfo_phase_q, lfo_phase_d;

  logic [31:0]       len_wide;
  logic [CNT_W-1:0]  len_eff;
  logic [CNT_W-1:0]  pos_next;
  logic              fresh;
  logic              wrap;

  // Effective length: zero acts as one, clamp to store depth
  always_comb begin
    if (cfg_i.delay_length == 16'd0) begin
      len_wide = 32'd1;
    end else if (32'(cfg_i.delay_length) > 32'(DELAY_DEPTH)) begin
      len_wide = 32'(DELAY_DEPTH);
    end else begin
      len_wide = 32'(cfg_i.delay_length);
    end
    len_eff = len_wide[CNT_W-1:0];
  end

  // Position advance and wrap; visited entries always form a prefix
  assign pos_next = CNT_W'({1'b0, write_pos_q}) + CNT_W'(1);
  assign wrap     = (pos_next >= len_eff);
  assign fresh    = (CNT_W'({1'b0, write_pos_q}) >= fill_q);

  always_comb begin
    write_pos_d = write_pos_q;
    lfo_phase_d = lfo_phase_q;
    fill_d      = fill_q;
    if (accept_i) begin
      if (wrap) begin
        write_pos_d = '0;
        lfo_phase_d = '0;
      end else begin
        write_pos_d = pos_next[ADDR_W-1:0];
        lfo_phase_d = lfo_phase_q + cfg_i.lfo_step;
      end
      if (fresh) begin
        fill_d = pos_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_pos_q <= '0;
      lfo_phase_q <= '0;
      fill_q      <= '0;
    end else begin
      write_pos_q <= write_pos_d;
      lfo_phase_q <= lfo_phase_d;
      fill_q      <= fill_d;
    end
  end

  // Command for the queue; chorus factor uses the phase before this step
  always_comb begin
    cmd_o.sample   = in_sample_i;
    cmd_o.pos      = write_pos_q;
    cmd_o.fresh    = fresh;
    cmd_o.chorus_f = ChorusLut[lfo_phase_q[15 -: SIN_W]];
  end

endmodule

`default_nettype wire

>>> src/ecde_cmd_queue.sv
// Short command queue between the front and back ends.
// Depends on ecde_pkg.
`default_nettype none

module ecde_cmd_queue
  import ecde_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  cmd_t  cmd_i,
  output logic  full_o,
  output logic  valid_o,
  output cmd_t  cmd_o,
  input  wire   pop_i
);

  cmd_t                  entry_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wptr_q, rptr_q;
  logic [CMDQ_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + CMDQ_PTR_W'(1);
      if (do_pop)  rptr_q <= rptr_q + CMDQ_PTR_W'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CMDQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CMDQ_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/ecde_back.sv
// Back end: delay store, read/compute/write pipeline and result queue.
// Depends on ecde_pkg and the assertion macro header.
`default_nettype none
`include "echo_chorus_delay_effect_defines.svh"

module ecde_back
  import ecde_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  cfg_t               cfg_i,
  input  wire                cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  output logic               res_empty_o,
  output logic signed [15:0] res_sample_o,
  input  wire                res_pop_i
);

  // Shift right truncating toward zero, then saturate to 16 bits
  function automatic logic signed [15:0] trunc_sat(input logic signed [35:0] v,
                                                   input int unsigned sh);
    logic signed [35:0] bias;
    logic signed [35:0] t;
    bias = v[35] ? ((36'sd1 <<< sh) - 36'sd1) : 36'sd0;
    t    = (v + bias) >>> sh;
    if (t > 36'sd32767) begin
      return 16'sh7fff;
    end else if (t < -36'sd32768) begin
      return 16'sh8000;
    end
    return t[15:0];
  endfunction

  logic signed [15:0] mem [DELAY_DEPTH];
  logic signed [15:0] rdata_q;

  logic               s2_valid_q;
  cmd_t               s2_cmd_q;
  logic               fwd_q;
  logic signed [15:0] fwd_data_q;

  logic               s2_done, rd_en, wr_en;
  logic               s2_stall, same_pos;
  logic               res_full, res_push;
  logic signed [15:0] d;
  logic signed [16:0] sum;
  logic signed [33:0] out_prod;
  logic signed [32:0] fb_prod;
  logic signed [31:0] x_sh;
  logic signed [33:0] ch_prod;
  logic signed [15:0] wdata;
  logic signed [15:0] y;

  logic signed [15:0]    res_q [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] res_wptr_q, res_rptr_q;
  logic [RESQ_CNT_W-1:0] res_cnt_q;
  logic                  res_do_pop;

  // Stage control: stage 2 retires into the result queue
  assign s2_done   = s2_valid_q && !res_full;
  assign s2_stall  = s2_valid_q && !s2_done;
  assign rd_en     = cmd_valid_i && (!s2_valid_q || s2_done);
  assign wr_en     = s2_done;
  assign cmd_pop_o = rd_en;
  assign res_push  = s2_done;
  assign same_pos  = wr_en && (cmd_i.pos == s2_cmd_q.pos);

  // Delayed sample: fresh entries read zero, a same-address write is forwarded
  always_comb begin
    if (s2_cmd_q.fresh) begin
      d = '0;
    end else if (fwd_q) begin
      d = fwd_data_q;
    end else begin
      d = rdata_q;
    end
  end

  // Datapath: output gain, echo feedback, chorus modulation
  assign sum      = 17'(s2_cmd_q.sample) + 17'(d);
  assign out_prod = sum * $signed({1'b0, cfg_i.output_gain});
  assign fb_prod  = d * $signed({1'b0, cfg_i.feedback_gain});
  assign x_sh     = {s2_cmd_q.sample, 16'h0000};
  assign ch_prod  = sum * $signed({1'b0, s2_cmd_q.chorus_f});
  assign y        = trunc_sat(36'(out_prod), 12);

  // New store value; off mode writes back what was read
  always_comb begin
    case (cfg_i.effect_mode)
      MODE_ECHO:   wdata = trunc_sat(36'(x_sh) + 36'(fb_prod), 16);
      MODE_CHORUS: wdata = trunc_sat(36'(ch_prod), 15);
      default:     wdata = d;
    endcase
  end

  // Delay store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s2_cmd_q.pos] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[cmd_i.pos];
    end
  end

  // Stage 2 payload and forward data
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s2_cmd_q   <= cmd_i;
      fwd_data_q <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (rd_en) begin
        s2_valid_q <= 1'b1;
        fwd_q      <= same_pos;
      end else if (s2_done) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // Result queue
  assign res_full     = (res_cnt_q == RESQ_CNT_W'(RESQ_DEPTH));
  assign res_empty_o  = (res_cnt_q == '0);
  assign res_sample_o = res_q[res_rptr_q];
  assign res_do_pop   = res_pop_i && !res_empty_o;

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[res_wptr_q] <= y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wptr_q <= '0;
      res_rptr_q <= '0;
      res_cnt_q  <= '0;
    end else begin
      if (res_push)   res_wptr_q <= res_wptr_q + RESQ_PTR_W'(1);
      if (res_do_pop) res_rptr_q <= res_rptr_q + RESQ_PTR_W'(1);
      if (res_push && !res_do_pop) begin
        res_cnt_q <= res_cnt_q + RESQ_CNT_W'(1);
      end else if (res_do_pop && !res_push) begin
        res_cnt_q <= res_cnt_q - RESQ_CNT_W'(1);
      end
    end
  end

  // Checks
  `ECDE_ASSERT_NEXT(a_fwd_on_hazard, rd_en && same_pos, fwd_q, "missed store forward")
  `ECDE_ASSERT_NOW(a_fresh_no_fwd, s2_valid_q && s2_cmd_q.fresh, !fwd_q, "fresh entry forwarded")
  `ECDE_ASSERT_NEXT(a_stall_holds, s2_stall, s2_valid_q && $stable(s2_cmd_q.pos), "item dropped")
  `ECDE_ASSERT_NEXT(a_push_visible, res_push, res_cnt_q != '0, "result transfer not queued")

endmodule

`default_nettype wire

>>> src/echo_chorus_delay_effect.sv
// Echo/chorus delay effect: one signed 16-bit sample in, one out.
// A taken sample goes via the command queue and stage 2 to the result ports.
// Throughput: one sample per cycle unless the result queue fills, bound by the
// single read and single write of the delay store per sample.
// Reset: registers take their defaults and the store reads as zero at once
// (a fill mark tracks visited entries), so there is no clearing pass.
`default_nettype none

module echo_chorus_delay_effect
  import ecde_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push,
  output logic               full,
  input  wire signed [15:0]  in_sample_i,
  output logic               empty,
  input  wire                pop,
  output logic signed [15:0] out_sample_o,
  input  wire                cfg_we_i,
  input  wire [2:0]          cfg_idx_i,
  input  wire [15:0]         cfg_wdata_i
);

  cfg_t cfg_q;
  cmd_t front_cmd, queue_cmd;
  logic accept;
  logic queue_valid, queue_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.effect_mode   <= MODE_OFF;
      cfg_q.delay_length  <= 16'd4800;
      cfg_q.feedback_gain <= 16'd32768;
      cfg_q.output_gain   <= 16'd4096;
      cfg_q.lfo_step      <= 16'd14;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:     cfg_q.effect_mode   <= cfg_wdata_i[1:0];
        REG_LENGTH:   cfg_q.delay_length  <= cfg_wdata_i;
        REG_FEEDBACK: cfg_q.feedback_gain <= cfg_wdata_i;
        REG_OUT_GAIN: cfg_q.output_gain   <= cfg_wdata_i;
        REG_LFO_STEP: cfg_q.lfo_step      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input transfer
  assign accept = push && !full;

  ecde_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .in_sample_i (in_sample_i),
    .cmd_o       (front_cmd)
  );

  ecde_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd),
    .pop_i   (queue_pop)
  );

  ecde_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_valid_i  (queue_valid),
    .cmd_i        (queue_cmd),
    .cmd_pop_o    (queue_pop),
    .res_empty_o  (empty),
    .res_sample_o (out_sample_o),
    .res_pop_i    (pop)
  );

endmodule

`default_nettype wire
